[rtl/fpc_pkg.sv]
package fpc_pkg;

    localparam int NUM_PLANES = 6;
    localparam int FRAC_SHIFT = 14;
    localparam int MARGIN_W   = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_MARGIN = 3'd6;

    typedef enum logic [1:0] {
        FUNC_POINT    = 2'd0,
        FUNC_SPHERE   = 2'd1,
        FUNC_TRIANGLE = 2'd2,
        FUNC_BOX      = 2'd3
    } t_func;

    typedef struct packed {
        logic signed [15:0] d;
        logic signed [15:0] nz;
        logic signed [15:0] ny;
        logic signed [15:0] nx;
    } t_plane;

endpackage

[rtl/fpc_cfg.sv]
module fpc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [fpc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fpc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output fpc_pkg::t_plane                     o_planes [fpc_pkg::NUM_PLANES],
    output logic [fpc_pkg::MARGIN_W-1:0]        o_margin
);
    import fpc_pkg::*;

    t_plane               r_planes [NUM_PLANES];
    logic [MARGIN_W-1:0]  r_margin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PLANES; k++) begin
                r_planes[k] <= '0;
            end
            r_margin <= '0;
        end else if (i_cfg_valid) begin
            for (int k = 0; k < NUM_PLANES; k++) begin
                if (i_cfg_index == CFG_IDX_W'(k)) begin
                    r_planes[k] <= t_plane'(i_cfg_data);
                end
            end
            if (i_cfg_index == REG_BOX_MARGIN) begin
                r_margin <= i_cfg_data[MARGIN_W-1:0];
            end
        end
    end

    assign o_planes = r_planes;
    assign o_margin = r_margin;

endmodule

[rtl/fpc_plane_dist.sv]
module fpc_plane_dist #(
    parameter int CW = 16,
    parameter int DW = 35
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  fpc_pkg::t_plane         i_plane,
    input  logic signed [CW-1:0]    i_a [3],
    input  logic signed [CW-1:0]    i_b [3],
    input  logic signed [CW-1:0]    i_c [3],
    output logic signed [DW-1:0]    o_da,
    output logic signed [DW-1:0]    o_db,
    output logic signed [DW-1:0]    o_dc,
    output logic signed [DW-1:0]    o_dbox
);
    import fpc_pkg::*;

    localparam int PW = CW + 16;

    logic signed [15:0]   n [3];
    logic signed [PW-1:0] r_pa [3];
    logic signed [PW-1:0] r_pb [3];
    logic signed [PW-1:0] r_pc [3];
    logic signed [PW-1:0] mx [3];
    logic signed [DW-1:0] dsc;

    assign n[0] = i_plane.nx;
    assign n[1] = i_plane.ny;
    assign n[2] = i_plane.nz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_pa[j] <= PW'(i_a[j]) * PW'(n[j]);
                r_pb[j] <= PW'(i_b[j]) * PW'(n[j]);
                r_pc[j] <= PW'(i_c[j]) * PW'(n[j]);
            end
        end
    end

    // The largest distance over the box corners takes, per axis, the larger product.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            mx[j] = (r_pb[j] > r_pa[j]) ? r_pb[j] : r_pa[j];
        end
    end

    assign dsc = DW'(i_plane.d) <<< FRAC_SHIFT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_da   <= DW'(r_pa[0]) + DW'(r_pa[1]) + DW'(r_pa[2]) + dsc;
            o_db   <= DW'(r_pb[0]) + DW'(r_pb[1]) + DW'(r_pb[2]) + dsc;
            o_dc   <= DW'(r_pc[0]) + DW'(r_pc[1]) + DW'(r_pc[2]) + dsc;
            o_dbox <= DW'(mx[0]) + DW'(mx[1]) + DW'(mx[2]) + dsc;
        end
    end

endmodule

[rtl/frustum_plane_culling.sv]
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_func, i_ax..i_cz, i_radius
// result    out        o_valid / i_stall   o_inside_res
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One transaction enters every cycle while o_stall is low.
// The stages are the input register, the plane multipliers, the distance adders and the
// threshold compare that feeds the output register.
// A stalled result holds the whole pipeline in place; configuration is always ready.
// Reset is synchronous and clears the valid bits and the configuration registers.
module frustum_plane_culling #(
    parameter int COORD_BITS  = 16,
    parameter int PLANE_COUNT = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_func,
    input  logic signed [COORD_BITS-1:0]        i_ax,
    input  logic signed [COORD_BITS-1:0]        i_ay,
    input  logic signed [COORD_BITS-1:0]        i_az,
    input  logic signed [COORD_BITS-1:0]        i_bx,
    input  logic signed [COORD_BITS-1:0]        i_by,
    input  logic signed [COORD_BITS-1:0]        i_bz,
    input  logic signed [COORD_BITS-1:0]        i_cx,
    input  logic signed [COORD_BITS-1:0]        i_cy,
    input  logic signed [COORD_BITS-1:0]        i_cz,
    input  logic [fpc_pkg::MARGIN_W-1:0]        i_radius,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_inside_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fpc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fpc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import fpc_pkg::*;

    localparam int NP = (PLANE_COUNT < NUM_PLANES) ? PLANE_COUNT : NUM_PLANES;
    localparam int DW = ((COORD_BITS + 18 > 31) ? COORD_BITS + 18 : 31) + 1;
    localparam int SW = DW + 1;

    t_plane               planes [NUM_PLANES];
    logic [MARGIN_W-1:0]  margin;
    logic                 en;

    logic                         r_v1, r_v2, r_v3, r_v4;
    t_func                        r_func1, r_func2, r_func3;
    logic [MARGIN_W-1:0]          r_rad1, r_rad2, r_rad3;
    logic signed [COORD_BITS-1:0] r_a1 [3];
    logic signed [COORD_BITS-1:0] r_b1 [3];
    logic signed [COORD_BITS-1:0] r_c1 [3];
    logic                         r_inside4;

    logic signed [DW-1:0] da [NP];
    logic signed [DW-1:0] db [NP];
    logic signed [DW-1:0] dc [NP];
    logic signed [DW-1:0] dbox [NP];
    logic signed [SW-1:0] thr;
    logic [NP-1:0]        rej;
    logic                 n_inside;

    assign en          = !(r_v4 && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    fpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_planes    (planes),
        .o_margin    (margin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_func1   <= t_func'(i_func);
            r_rad1    <= i_radius;
            r_a1[0]   <= i_ax;
            r_a1[1]   <= i_ay;
            r_a1[2]   <= i_az;
            r_b1[0]   <= i_bx;
            r_b1[1]   <= i_by;
            r_b1[2]   <= i_bz;
            r_c1[0]   <= i_cx;
            r_c1[1]   <= i_cy;
            r_c1[2]   <= i_cz;
            r_func2   <= r_func1;
            r_rad2    <= r_rad1;
            r_func3   <= r_func2;
            r_rad3    <= r_rad2;
            r_inside4 <= n_inside;
        end
    end

    for (genvar p = 0; p < NP; p++) begin : g_plane
        fpc_plane_dist #(
            .CW (COORD_BITS),
            .DW (DW)
        ) u_dist (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_plane (planes[p]),
            .i_a     (r_a1),
            .i_b     (r_b1),
            .i_c     (r_c1),
            .o_da    (da[p]),
            .o_db    (db[p]),
            .o_dc    (dc[p]),
            .o_dbox  (dbox[p])
        );
    end

    always_comb begin
        case (r_func3)
            FUNC_SPHERE: thr = SW'(r_rad3) <<< FRAC_SHIFT;
            FUNC_BOX:    thr = SW'(margin) <<< FRAC_SHIFT;
            default:     thr = '0;
        endcase
    end

    always_comb begin
        logic signed [SW-1:0] sa;
        logic signed [SW-1:0] sbox;
        for (int p = 0; p < NP; p++) begin
            sa   = SW'(da[p]) + thr;
            sbox = SW'(dbox[p]) + thr;
            case (r_func3)
                FUNC_POINT, FUNC_SPHERE: rej[p] = (sa <= 0);
                FUNC_TRIANGLE: rej[p] = (da[p] <= 0) && (db[p] <= 0) && (dc[p] <= 0);
                FUNC_BOX:      rej[p] = (sbox <= 0);
                default:       rej[p] = 1'b0;
            endcase
        end
        n_inside = ~|rej;
    end

    assign o_valid      = r_v4;
    assign o_inside_res = r_inside4;

endmodule
